// File: rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Types and character constants shared by the integer text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  localparam int WORD_BITS   = 32;
  localparam int OFFSET_BITS = 16;
  localparam int BASE_BITS   = 6;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_NUMBER_BASE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIGNED_MODE = 1'd1;

  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_FOLD  = 8'hdf;
  localparam logic [7:0] LETTER_BIAS = 8'd10;

  typedef enum logic [3:0] {
    PH_LEAD     = 4'b0001,
    PH_POSTSIGN = 4'b0010,
    PH_DIGITS   = 4'b0100,
    PH_STOP     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]   result_word;
    logic                   stopped;
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   negative;
  } result_t;

  typedef struct packed {
    phase_t                 phase;
    logic                   minus_seen;
    logic [WORD_BITS-1:0]   accumulator;
    logic [BASE_BITS-1:0]   active_base;
    logic                   base_undecided;
    logic [OFFSET_BITS-1:0] consumed_count;
  } parse_state_t;

endpackage

`default_nettype wire

// File: rtl/core/itp_step.sv
// ----------------------------------------------------------------------------
// itp_step
// Next parse state and result for one character, given the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_step import itp_pkg::*; (
  input  wire parse_state_t          cur,
  input  wire item_t                 item,
  input  wire logic [BASE_BITS-1:0]  number_base,
  input  wire logic                  signed_mode,
  output parse_state_t               nxt,
  output result_t                    res
);

  parse_state_t         st;
  logic [7:0]           c;
  logic [7:0]           up;
  logic                 is_space;
  logic                 is_digit;
  logic                 is_alpha;
  logic                 is_x;
  logic                 do_digit;
  logic                 do_mac;
  logic                 take;
  logic [BASE_BITS-1:0] mul_base;
  logic [BASE_BITS-1:0] digit_val;
  logic [WORD_BITS-1:0] product;

  always_comb begin
    c  = item.ch;
    up = c & CASE_FOLD;
    is_space = c inside {CH_SPACE, [CH_TAB:CH_CR]};
    is_digit = c inside {[CH_ZERO:CH_NINE]};
    is_alpha = c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
    is_x     = (c == CH_UPPER_X) || (c == CH_LOWER_X);

    // a new string starts from a cleared state
    if (item.first) begin
      st.phase          = PH_LEAD;
      st.minus_seen     = 1'b0;
      st.accumulator    = '0;
      st.active_base    = number_base;
      st.base_undecided = (number_base == BASE_AUTO);
      st.consumed_count = '0;
    end else begin
      st = cur;
    end

    nxt      = st;
    do_digit = 1'b0;
    take     = 1'b0;

    case (st.phase)
      PH_LEAD: begin
        if (is_space) begin
          take = 1'b1;
        end else if (signed_mode && c == CH_MINUS) begin
          nxt.minus_seen = 1'b1;
          nxt.phase      = PH_POSTSIGN;
          take           = 1'b1;
        end else if (signed_mode && c == CH_PLUS) begin
          nxt.phase = PH_POSTSIGN;
          take      = 1'b1;
        end else begin
          nxt.phase = PH_DIGITS;
          do_digit  = 1'b1;
        end
      end
      PH_POSTSIGN: begin
        if (is_space) begin
          take = 1'b1;
        end else begin
          nxt.phase = PH_DIGITS;
          do_digit  = 1'b1;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      PH_STOP:   do_digit = 1'b0;
      default:   do_digit = 1'b0;
    endcase

    // resolve the base before the multiply-add
    mul_base  = st.active_base;
    digit_val = {2'b00, c[3:0]};
    do_mac    = 1'b0;
    if (do_digit) begin
      if (is_digit) begin
        if (st.active_base == BASE_AUTO) begin
          if (c == CH_ZERO) begin
            mul_base = BASE_OCT;  // keep undecided for a following x
          end else begin
            mul_base           = BASE_DEC;
            nxt.base_undecided = 1'b0;
          end
        end else begin
          nxt.base_undecided = 1'b0;
        end
        nxt.active_base = mul_base;
        do_mac          = 1'b1;
        take            = 1'b1;
      end else if (is_alpha) begin
        if (is_x) begin
          if (st.active_base == BASE_AUTO ||
              (st.active_base == BASE_OCT && st.base_undecided)) begin
            nxt.active_base    = BASE_HEX;
            nxt.base_undecided = 1'b0;
            take               = 1'b1;
          end else if (st.active_base == BASE_HEX) begin
            take = 1'b1;
          end else begin
            nxt.phase = PH_STOP;
          end
        end else if (st.active_base <= BASE_DEC) begin
          nxt.phase = PH_STOP;
        end else begin
          digit_val = BASE_BITS'(up - CH_UPPER_A + LETTER_BIAS);
          do_mac    = 1'b1;
          take      = 1'b1;
        end
      end else begin
        nxt.phase = PH_STOP;
      end
    end

    product = WORD_BITS'(st.accumulator * WORD_BITS'(mul_base));
    if (do_mac) begin
      nxt.accumulator = product + WORD_BITS'(digit_val);
    end

    // saturate the consumed count
    if (take && st.consumed_count != OFFSET_MAX) begin
      nxt.consumed_count = st.consumed_count + 1'b1;
    end

    res.result_word = nxt.minus_seen ? (WORD_BITS'(0) - nxt.accumulator) : nxt.accumulator;
    res.stopped     = (nxt.phase == PH_STOP);
    res.end_offset  = nxt.consumed_count;
    res.negative    = nxt.minus_seen;
  end

endmodule

`default_nettype wire

// File: rtl/core/integer_text_parse.sv
// Each accepted character passes through the input register and then the result
// register. Throughput: one character per cycle while out_stall holds no result
// beat back; the parse state loops through a single multiply-add by the active
// base, settled in the cycle the character leaves the input register.
// Reset (rst, synchronous): number_base = 10, signed_mode = 1, parse state
// cleared to the leading whitespace phase, both register stages emptied.
// ----------------------------------------------------------------------------
// integer_text_parse
// Streaming integer parser: one ASCII character in, one result beat out.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_text_parse import itp_pkg::*; (
  input  wire  logic                    clk,
  input  wire  logic                    rst,
  input  wire  logic                    cfg_we,
  input  wire  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire  logic [BASE_BITS-1:0]    cfg_data,
  input  wire  logic                    in_valid,
  output logic                          in_stall,
  input  wire  item_t                   in_data,
  output logic                          out_valid,
  input  wire  logic                    out_stall,
  output result_t                       out_data
);

  logic [BASE_BITS-1:0] number_base;
  logic                 signed_mode;
  logic                 inq_valid;
  item_t                inq;
  parse_state_t         state;
  parse_state_t         state_next;
  result_t              res_next;
  logic                 advance;

  itp_step u_step (
    .cur         (state),
    .item        (inq),
    .number_base (number_base),
    .signed_mode (signed_mode),
    .nxt         (state_next),
    .res         (res_next)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = inq_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
      signed_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUMBER_BASE: number_base <= cfg_data;
        REG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register: load whenever it is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (!in_stall) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      inq <= in_data;
    end
  end

  // result register and parse state advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid            <= 1'b0;
      state.phase          <= PH_LEAD;
      state.minus_seen     <= 1'b0;
      state.accumulator    <= '0;
      state.active_base    <= BASE_RESET;
      state.base_undecided <= (BASE_RESET == BASE_AUTO);
      state.consumed_count <= '0;
    end else if (advance) begin
      out_valid <= inq_valid;
      if (inq_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && inq_valid) begin
      out_data <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_text_parse. Character beats are fed from a
// queue in random bursts while the result side stalls on its own pattern.
// Every accepted character is run through a local parser model, and each
// result beat is checked against the oldest prediction. Register settings
// cover auto, binary, decimal, octal, hex, base 36 and out-of-range bases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_CHARS  = 120;
  localparam int RANDOM_PHASES = 10;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [BASE_BITS-1:0]    cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  item_t                   in_data   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  result_t                 out_data;

  integer_text_parse i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // register copies and parse state of the local model
  logic [BASE_BITS-1:0] base_reg;
  logic                 signed_reg;
  parse_state_t         pst;

  item_t   char_queue[$];
  result_t predicted_parse[$];
  result_t want;

  logic next_first  = 1'b0;

  int n_predicted = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int n_strings   = 0;
  int n_settings  = 0;
  int cycles      = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  // negative entry: pick a random register value
  int phase_base [RANDOM_PHASES] = '{10, 0, 16, 36, 1, 63, 8, 2, 0, -1};
  int phase_sign [RANDOM_PHASES] = '{1, 1, 0, 1, 1, 0, 1, 0, 0, -1};

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void clear_parse_state();
    pst.phase          = PH_LEAD;
    pst.minus_seen     = 1'b0;
    pst.accumulator    = '0;
    pst.active_base    = base_reg;
    pst.base_undecided = (base_reg == BASE_AUTO);
    pst.consumed_count = '0;
  endfunction

  function automatic void bump_offset();
    if (pst.consumed_count != OFFSET_MAX)
      pst.consumed_count = pst.consumed_count + 1'b1;
  endfunction

  function automatic void step_digit(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (pst.active_base == BASE_AUTO) begin
        // a leading zero means octal but leaves room for a hex marker
        if (c == CH_ZERO) begin
          pst.active_base = BASE_OCT;
        end else begin
          pst.active_base    = BASE_DEC;
          pst.base_undecided = 1'b0;
        end
      end else begin
        pst.base_undecided = 1'b0;
      end
      pst.accumulator = pst.accumulator * WORD_BITS'(pst.active_base)
                        + WORD_BITS'(c - CH_ZERO);
      bump_offset();
    end else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                 (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
      if (c == CH_UPPER_X || c == CH_LOWER_X) begin
        if (pst.active_base == BASE_AUTO ||
            (pst.active_base == BASE_OCT && pst.base_undecided)) begin
          pst.active_base    = BASE_HEX;
          pst.base_undecided = 1'b0;
          bump_offset();
        end else if (pst.active_base == BASE_HEX) begin
          bump_offset();
        end else begin
          pst.phase = PH_STOP;
        end
      end else if (pst.active_base <= BASE_DEC) begin
        pst.phase = PH_STOP;
      end else begin
        pst.accumulator = pst.accumulator * WORD_BITS'(pst.active_base)
                          + WORD_BITS'((c & CASE_FOLD) - CH_UPPER_A + LETTER_BIAS);
        bump_offset();
      end
    end else begin
      pst.phase = PH_STOP;
    end
  endfunction

  function automatic result_t parse_char(item_t it);
    result_t r;
    if (it.first)
      clear_parse_state();
    case (pst.phase)
      PH_LEAD: begin
        if (is_space(it.ch)) begin
          bump_offset();
        end else if (signed_reg && it.ch == CH_MINUS) begin
          pst.minus_seen = 1'b1;
          pst.phase      = PH_POSTSIGN;
          bump_offset();
        end else if (signed_reg && it.ch == CH_PLUS) begin
          pst.phase = PH_POSTSIGN;
          bump_offset();
        end else begin
          pst.phase = PH_DIGITS;
          step_digit(it.ch);
        end
      end
      PH_POSTSIGN: begin
        if (is_space(it.ch)) begin
          bump_offset();
        end else begin
          pst.phase = PH_DIGITS;
          step_digit(it.ch);
        end
      end
      PH_DIGITS: step_digit(it.ch);
      default: ;
    endcase
    r.result_word = pst.minus_seen ? -pst.accumulator : pst.accumulator;
    r.stopped     = (pst.phase == PH_STOP);
    r.end_offset  = pst.consumed_count;
    r.negative    = pst.minus_seen;
    return r;
  endfunction

  function automatic void add_char(logic [7:0] c);
    item_t it;
    it.ch      = c;
    it.first   = next_first;
    next_first = 1'b0;
    char_queue.push_back(it);
  endfunction

  function automatic logic [7:0] space_char();
    if ($urandom_range(0, 4) == 0)
      return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic logic [7:0] number_char();
    if (base_reg <= BASE_DEC && base_reg != BASE_AUTO && $urandom_range(0, 7) != 0)
      return CH_ZERO + 8'($urandom_range(0, 9));
    case ($urandom_range(0, 2))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return CH_UPPER_A + 8'($urandom_range(0, 25));
      default: return CH_LOWER_A + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // one string: mostly well formed with random content, the rest raw bytes
  function automatic void gen_string();
    n_strings++;
    next_first = 1'b1;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        add_char(8'($urandom_range(0, 255)));
        next_first = ($urandom_range(0, 7) == 0);
      end
      next_first = 1'b0;
    end else begin
      repeat ($urandom_range(0, 2)) add_char(space_char());
      if ($urandom_range(0, 1)) begin
        add_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        repeat ($urandom_range(0, 1)) add_char(space_char());
      end
      case ($urandom_range(0, 5))
        0: add_char(CH_ZERO);
        1: begin
          add_char(CH_ZERO);
          add_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
        end
        2: add_char(CH_LOWER_X);
        default: ;
      endcase
      repeat ($urandom_range(0, 12)) add_char(number_char());
      repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 2) == 0)
        add_char(8'h00);
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (char_queue.size() != 0 || in_valid || predicted_parse.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [BASE_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_NUMBER_BASE)
      base_reg = val;
    else
      signed_reg = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // driver: bursts of character beats with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_parse.push_back(parse_char(in_data));
        n_predicted <= n_predicted + 1;
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_queue.size() > 0) begin
          in_data  <= char_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 160);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (stall_left % 7) < 3;
      endcase
    end
  end

  // monitor: n_predicted still holds its value from before this edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (n_checked >= n_predicted) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result beat: word %h stop %b offset %0d neg %b",
                   out_data.result_word, out_data.stopped, out_data.end_offset,
                   out_data.negative);
      end else begin
        want = predicted_parse.pop_front();
        if (out_data.result_word !== want.result_word ||
            out_data.stopped !== want.stopped ||
            out_data.end_offset !== want.end_offset ||
            out_data.negative !== want.negative) begin
          n_errors++;
          if (n_errors <= 10)
            $display("beat %0d: expected word %h stop %b offset %0d neg %b, got word %h stop %b offset %0d neg %b",
                     n_checked, want.result_word, want.stopped, want.end_offset,
                     want.negative, out_data.result_word, out_data.stopped,
                     out_data.end_offset, out_data.negative);
        end
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still awaited", cycles,
               predicted_parse.size());
      $display("integer_text_parse regression: fail");
      $finish;
    end
  end

  initial begin
    logic [BASE_BITS-1:0] bdata;
    logic [BASE_BITS-1:0] sdata;
    base_reg   = BASE_RESET;
    signed_reg = 1'b1;
    clear_parse_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings; the first string needs no first flag
    next_first = 1'b0;
    add_char(CH_SPACE);
    add_char(CH_MINUS);
    add_char(CH_TAB);
    add_char(CH_ZERO + 8'd1);
    add_char(CH_ZERO + 8'd2);
    add_char(CH_LOWER_A);
    add_char(CH_LOWER_Z);
    next_first = 1'b1;
    add_char(CH_PLUS);
    add_char(CH_NINE);
    add_char(8'h00);
    next_first = 1'b1;
    add_char(8'hff);
    wait_drained();

    // auto base, unsigned: hex marker, skipped x, octal prefix, stray sign
    write_reg(REG_NUMBER_BASE, BASE_AUTO);
    write_reg(REG_SIGNED_MODE, '0);
    n_settings++;
    next_first = 1'b1;
    add_char(CH_ZERO);
    add_char(CH_LOWER_X);
    add_char(CH_ZERO + 8'd1);
    add_char(CH_LOWER_A + 8'd5);
    add_char(CH_UPPER_X);
    add_char(CH_LOWER_A + 8'd6);
    next_first = 1'b1;
    add_char(CH_ZERO);
    add_char(CH_ZERO + 8'd1);
    add_char(CH_ZERO + 8'd7);
    add_char(CH_LOWER_X);
    next_first = 1'b1;
    add_char(CH_MINUS);
    add_char(CH_ZERO + 8'd5);
    wait_drained();

    for (int i = 0; i < RANDOM_PHASES; i++) begin
      bdata = (phase_base[i] < 0) ? BASE_BITS'($urandom_range(0, 63))
                                  : BASE_BITS'(phase_base[i]);
      // upper bits of the mode write are don't-care
      sdata    = BASE_BITS'($urandom_range(0, 63));
      sdata[0] = (phase_sign[i] < 0) ? 1'($urandom_range(0, 1)) : 1'(phase_sign[i]);
      write_reg(REG_NUMBER_BASE, bdata);
      write_reg(REG_SIGNED_MODE, sdata);
      n_settings++;
      while (char_queue.size() < PHASE_CHARS)
        gen_string();
      wait_drained();
    end
    repeat (10) @(negedge clk);

    $display("%0d characters in, %0d result beats checked, %0d register settings",
             n_accepted, n_checked, n_settings);
    $display("%0d random strings under bursty input and result back-pressure",
             n_strings);
    if (n_errors == 0) begin
      $display("integer_text_parse regression: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("integer_text_parse regression: fail");
    end
    $finish;
  end

endmodule

// File: integer_text_parse.f
rtl/core/itp_pkg.sv
rtl/core/itp_step.sv
rtl/core/integer_text_parse.sv
verif/tb.sv
